/* rtl/qsl_pkg.sv */
// ============================================================================
// qsl_pkg
// Shared types for the quicksort engine: sequencer state encoding.
// ============================================================================
`default_nettype none

package qsl_pkg;

  // Sequencer states: load, partition scan, swaps, range stack, emission
  typedef enum logic [4:0] {
    S_LOAD,
    S_PIV_RD,
    S_PIV_LD,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SW_RD,
    S_SW_WJ,
    S_SW_WI,
    S_FIN_RD,
    S_FIN_WH,
    S_FIN_WI,
    S_PUSH_A,
    S_PUSH_B,
    S_POP,
    S_POP_LD,
    S_EMIT_RD,
    S_EMIT_LD
  } state_e;

endpackage

`default_nettype wire

/* rtl/qsl_ram.sv */
// ============================================================================
// qsl_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Read data holds until the next read.
// ============================================================================
`default_nettype none

module qsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/quicksort_lomuto_engine.sv */
// ============================================================================
// quicksort_lomuto_engine
// Streaming in-place quicksort (Lomuto partition) over an element RAM.
// ============================================================================
// Usage: stream signed values in, one item per cycle while loading; the item
// with tlast set closes the set and starts the sort. Items past MAX_ELEMENTS
// are dropped and flag overflow (tuser) on every result of that run. The sort
// runs in one element RAM and one range-stack RAM (both single write, single
// registered read). Each partition fetches the pivot, scans and compares each
// element, swaps where data must move, places the pivot and pushes the
// ranges left to sort; each pushed range is popped in turn. Emission reads
// each result and hands it to the output register while the output is free.
// The sort time depends on the data; an already ordered set is the worst case.
// The input is not ready again until the last result of the run is in the
// output register; that register drains on its own.
`default_nettype none

module quicksort_lomuto_engine #(
  parameter int MAX_ELEMENTS = 64,
  parameter int VALUE_BITS   = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // value
  input  wire logic                                s_axis_tlast,  // last
  // Result stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic      [((VALUE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // sorted_value
  output logic                                     m_axis_tlast,  // final_res
  output logic                                     m_axis_tuser   // overflow
);

  localparam int IDX_W = $clog2(MAX_ELEMENTS);
  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int SK_W  = 2 * IDX_W;

  qsl_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]      count_q, count_d, n_cnt;
  logic                  drop_q, drop_d;
  logic [CNT_W-1:0]      sp_q, sp_d, sp_m1;
  logic [IDX_W-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]      i_q, i_d, j_q, j_d, k_q, k_d;
  logic [VALUE_BITS-1:0] pivot_q, pivot_d, tmp_q, tmp_d;

  logic                  out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0] out_data_q, out_data_d;
  logic                  out_last_q, out_last_d, out_user_q, out_user_d;
  logic                  out_free;

  // Element RAM ports
  logic                  st_we, st_re;
  logic [IDX_W-1:0]      st_waddr, st_raddr;
  logic [VALUE_BITS-1:0] st_wdata, st_rdata;

  // Range stack RAM ports
  logic                  sk_we, sk_re;
  logic [IDX_W-1:0]      sk_waddr, sk_raddr;
  logic [SK_W-1:0]       sk_wdata, sk_rdata;

  // Partition bounds checks (one bit wider to avoid wrap)
  logic [IDX_W:0] i_ext, lo_ext, hi_ext;

  qsl_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(MAX_ELEMENTS)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(st_waddr),
    .wdata_i(st_wdata),
    .re_i   (st_re),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  qsl_ram #(
    .WIDTH(SK_W),
    .DEPTH(MAX_ELEMENTS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (sk_we),
    .waddr_i(sk_waddr),
    .wdata_i(sk_wdata),
    .re_i   (sk_re),
    .raddr_i(sk_raddr),
    .rdata_o(sk_rdata)
  );

  assign i_ext  = {1'b0, i_q};
  assign lo_ext = {1'b0, lo_q};
  assign hi_ext = {1'b0, hi_q};
  assign sp_m1  = sp_q - CNT_W'(1);

  assign s_axis_tready = (state_q == qsl_pkg::S_LOAD);
  assign out_free      = !out_valid_q || m_axis_tready;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qsl_pkg::S_LOAD;
      count_q     <= '0;
      drop_q      <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      drop_q      <= drop_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    i_q        <= i_d;
    j_q        <= j_d;
    k_q        <= k_d;
    pivot_q    <= pivot_d;
    tmp_q      <= tmp_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_user_q <= out_user_d;
  end

  // Next state, RAM control and datapath updates
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    drop_d      = drop_q;
    sp_d        = sp_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    pivot_d     = pivot_q;
    tmp_d       = tmp_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    n_cnt       = count_q;
    st_we       = 1'b0;
    st_re       = 1'b0;
    st_waddr    = j_q;
    st_raddr    = j_q;
    st_wdata    = tmp_q;
    sk_we       = 1'b0;
    sk_re       = 1'b0;
    sk_waddr    = sp_q[IDX_W-1:0];
    sk_raddr    = sp_m1[IDX_W-1:0];
    sk_wdata    = {lo_q, hi_q};

    unique case (state_q)
      // Store incoming items; the last one starts the sort
      qsl_pkg::S_LOAD: begin
        if (s_axis_tvalid) begin
          if (count_q < CNT_W'(MAX_ELEMENTS)) begin
            st_we    = 1'b1;
            st_waddr = count_q[IDX_W-1:0];
            st_wdata = s_axis_tdata[VALUE_BITS-1:0];
            n_cnt    = count_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          count_d = n_cnt;
          if (s_axis_tlast) begin
            sp_d = '0;
            k_d  = '0;
            if (n_cnt >= CNT_W'(2)) begin
              lo_d    = '0;
              hi_d    = IDX_W'(n_cnt - CNT_W'(1));
              state_d = qsl_pkg::S_PIV_RD;
            end else begin
              state_d = qsl_pkg::S_EMIT_RD;
            end
          end
        end
      end
      // Fetch pivot (last element of the range)
      qsl_pkg::S_PIV_RD: begin
        st_re    = 1'b1;
        st_raddr = hi_q;
        i_d      = lo_q;
        j_d      = lo_q;
        state_d  = qsl_pkg::S_PIV_LD;
      end
      qsl_pkg::S_PIV_LD: begin
        pivot_d = st_rdata;
        state_d = qsl_pkg::S_SCAN_RD;
      end
      // Scan: read element j
      qsl_pkg::S_SCAN_RD: begin
        if (j_q == hi_q) begin
          state_d = qsl_pkg::S_FIN_RD;
        end else begin
          st_re    = 1'b1;
          st_raddr = j_q;
          state_d  = qsl_pkg::S_SCAN_CMP;
        end
      end
      // Compare against pivot; swap into the low partition when smaller
      qsl_pkg::S_SCAN_CMP: begin
        tmp_d = st_rdata;
        if ($signed(st_rdata) < $signed(pivot_q)) begin
          if (i_q == j_q) begin
            i_d     = i_q + IDX_W'(1);
            j_d     = j_q + IDX_W'(1);
            state_d = qsl_pkg::S_SCAN_RD;
          end else begin
            state_d = qsl_pkg::S_SW_RD;
          end
        end else begin
          j_d     = j_q + IDX_W'(1);
          state_d = qsl_pkg::S_SCAN_RD;
        end
      end
      qsl_pkg::S_SW_RD: begin
        st_re    = 1'b1;
        st_raddr = i_q;
        state_d  = qsl_pkg::S_SW_WJ;
      end
      qsl_pkg::S_SW_WJ: begin
        st_we    = 1'b1;
        st_waddr = j_q;
        st_wdata = st_rdata;
        state_d  = qsl_pkg::S_SW_WI;
      end
      qsl_pkg::S_SW_WI: begin
        st_we    = 1'b1;
        st_waddr = i_q;
        st_wdata = tmp_q;
        i_d      = i_q + IDX_W'(1);
        j_d      = j_q + IDX_W'(1);
        state_d  = qsl_pkg::S_SCAN_RD;
      end
      // Place pivot at its final slot i
      qsl_pkg::S_FIN_RD: begin
        if (i_q == hi_q) begin
          state_d = qsl_pkg::S_PUSH_A;
        end else begin
          st_re    = 1'b1;
          st_raddr = i_q;
          state_d  = qsl_pkg::S_FIN_WH;
        end
      end
      qsl_pkg::S_FIN_WH: begin
        st_we    = 1'b1;
        st_waddr = hi_q;
        st_wdata = st_rdata;
        state_d  = qsl_pkg::S_FIN_WI;
      end
      qsl_pkg::S_FIN_WI: begin
        st_we    = 1'b1;
        st_waddr = i_q;
        st_wdata = pivot_q;
        state_d  = qsl_pkg::S_PUSH_A;
      end
      // Push upper range (p+1, hi) then lower range (lo, p-1)
      qsl_pkg::S_PUSH_A: begin
        if (i_ext + (IDX_W+1)'(1) < hi_ext) begin
          sk_we    = 1'b1;
          sk_wdata = {i_q + IDX_W'(1), hi_q};
          sp_d     = sp_q + CNT_W'(1);
        end
        state_d = qsl_pkg::S_PUSH_B;
      end
      qsl_pkg::S_PUSH_B: begin
        if (lo_ext + (IDX_W+1)'(1) < i_ext) begin
          sk_we    = 1'b1;
          sk_wdata = {lo_q, i_q - IDX_W'(1)};
          sp_d     = sp_q + CNT_W'(1);
        end
        state_d = qsl_pkg::S_POP;
      end
      // Pop the next pending range, or finish
      qsl_pkg::S_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = qsl_pkg::S_EMIT_RD;
        end else begin
          sk_re   = 1'b1;
          sp_d    = sp_m1;
          state_d = qsl_pkg::S_POP_LD;
        end
      end
      qsl_pkg::S_POP_LD: begin
        lo_d    = sk_rdata[SK_W-1:IDX_W];
        hi_d    = sk_rdata[IDX_W-1:0];
        state_d = qsl_pkg::S_PIV_RD;
      end
      // Emission: read element k, then hand it to the output register
      qsl_pkg::S_EMIT_RD: begin
        st_re    = 1'b1;
        st_raddr = k_q;
        state_d  = qsl_pkg::S_EMIT_LD;
      end
      qsl_pkg::S_EMIT_LD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = st_rdata;
          out_last_d  = (CNT_W'(k_q) + CNT_W'(1)) == count_q;
          out_user_d  = drop_q;
          if ((CNT_W'(k_q) + CNT_W'(1)) == count_q) begin
            count_d = '0;
            drop_d  = 1'b0;
            sp_d    = '0;
            state_d = qsl_pkg::S_LOAD;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = qsl_pkg::S_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = qsl_pkg::S_LOAD;
      end
    endcase
  end

  // Output register to ports, upper padding zero
  always_comb begin
    m_axis_tdata                 = '0;
    m_axis_tdata[VALUE_BITS-1:0] = out_data_q;
  end
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

  // Range stack never holds more than half the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CNT_W'(MAX_ELEMENTS / 2))
    else $error("range stack depth exceeded");

  // A popped or initial range always has at least two elements
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qsl_pkg::S_PIV_RD) |-> (lo_q < hi_q))
    else $error("degenerate range entered partition");

  // Partition invariant: lo <= i <= j <= hi during the scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qsl_pkg::S_SCAN_RD) |->
      (lo_q <= i_q) && (i_q <= j_q) && (j_q <= hi_q))
    else $error("partition indexes out of order");

  // Output register is never overwritten while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    else $error("pending result lost");

endmodule

`default_nettype wire

/* tb/tb_quicksort_lomuto_engine.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_quicksort_lomuto_engine
// Self-checking bench for the streaming quicksort engine. Sets of signed
// values go in, and each set's sorted values are predicted and checked in
// order. Tail marking and the overflow flag are checked on every result.
// ----------------------------------------------------------------------------

// One predicted output item
typedef struct packed {
  logic signed [31:0] value;
  logic               final_res;
  logic               overflow;
} sorted_item_t;

// Predicts sorted output per set and checks it against the result stream
class sort_scoreboard;
  int                 depth;
  logic signed [31:0] set_q[$];
  bit                 dropped;
  sorted_item_t       sorted_q[$];
  int                 failures;
  int                 items_in;
  int                 results_checked;
  int                 runs_done;
  int                 overflow_runs;

  function new(int max_elements);
    depth = max_elements;
  endfunction

  // Store an accepted input; a set closed by tlast is sorted into the queue
  function void note_input(logic [31:0] value, logic last);
    logic signed [31:0] ordered[$];
    logic signed [31:0] key;
    int                 j;
    sorted_item_t       item;
    items_in++;
    if (set_q.size() < depth) set_q.push_back(value);
    else dropped = 1'b1;
    if (!last) return;
    // insertion sort, signed ascending
    ordered = set_q;
    for (int i = 1; i < ordered.size(); i++) begin
      key = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > key) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = key;
    end
    foreach (ordered[k]) begin
      item.value     = ordered[k];
      item.final_res = (k == ordered.size() - 1);
      item.overflow  = dropped;
      sorted_q.push_back(item);
    end
    runs_done++;
    if (dropped) overflow_runs++;
    set_q.delete();
    dropped = 1'b0;
  endfunction

  // Compare one accepted result with the oldest prediction
  function void check_result(logic [31:0] value, logic last, logic ovf);
    sorted_item_t want;
    if (sorted_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: unexpected result value %0d last %0b ovf %0b",
                 $signed(value), last, ovf);
      return;
    end
    want = sorted_q.pop_front();
    results_checked++;
    if (value !== want.value || last !== want.final_res || ovf !== want.overflow) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result %0d: want value %0d last %0b ovf %0b, got %0d %0b %0b",
                 results_checked, want.value, want.final_res, want.overflow,
                 $signed(value), last, ovf);
    end
  endfunction
endclass

module tb_quicksort_lomuto_engine;

  localparam int MAX_ELEMENTS = 64;
  localparam int VALUE_BITS   = 32;
  localparam int STALL_LIMIT  = 100000;
  localparam int LONG_HOLD    = 8000;

  // Value shapes for generated sets
  typedef enum int {
    PAT_FULL,
    PAT_NARROW,
    PAT_ASCEND,
    PAT_DESCEND,
    PAT_EXTREME
  } value_pattern_e;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // value
  logic        s_axis_tlast;   // last
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // sorted_value
  logic        m_axis_tlast;   // final_res
  logic        m_axis_tuser;   // overflow

  sort_scoreboard sb;
  bit             idling_on;
  bit             hold_req;
  int             items_sent;
  int             stall_cycles;

  quicksort_lomuto_engine #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .VALUE_BITS  (VALUE_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Handshake monitor: inputs feed the predictor, results get checked
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ERROR: no item moved for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // Offer one item and hold it until taken; gaps come before the item
  task automatic send_item(input logic [31:0] value, input logic last);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tdata  <= value;
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic [31:0] draw_value(value_pattern_e pat, int idx);
    case (pat)
      PAT_NARROW:  return $urandom_range(0, 8) - 4;
      PAT_ASCEND:  return idx * 7 - 100;
      PAT_DESCEND: return 100 - idx * 7;
      PAT_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          3:       return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default:     return $urandom;
    endcase
  endfunction

  task automatic send_set(input int n, input value_pattern_e pat);
    for (int i = 0; i < n; i++) send_item(draw_value(pat, i), i == n - 1);
  endtask

  // Park the sender until every predicted result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.sorted_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    int             n;
    value_pattern_e pat;
    sb            = new(MAX_ELEMENTS);
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    idling_on     = 1'b1;
    hold_req      = 1'b0;
    items_sent    = 0;
    stall_cycles  = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: one-element run, two-element run, extremes with duplicates
    send_item(32'd5, 1'b1);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hffff_ffff, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h7fff_ffff, 1'b1);
    // already sorted, reversed, all equal
    send_set(5, PAT_ASCEND);
    send_set(5, PAT_DESCEND);
    for (int i = 0; i < 4; i++) send_item(32'hdead_beef, i == 3);
    wait_drained();

    // Store exactly full, worst-case order for a last-element pivot
    send_set(MAX_ELEMENTS, PAT_ASCEND);

    // Overflow run under a long receiver hold-off; the next set backs up
    hold_req = 1'b1;
    send_set(MAX_ELEMENTS + 6, PAT_FULL);
    send_set(12, PAT_FULL);
    wait_drained();

    // Random sets, mostly short, until about 40 more items have gone in
    n = items_sent + 40;
    while (items_sent < n) begin
      if (items_sent > n - 15) idling_on = 1'b0;
      pat = value_pattern_e'($urandom_range(0, 4));
      if ($urandom_range(0, 7) == 0) send_set($urandom_range(17, 40), pat);
      else send_set($urandom_range(1, 16), pat);
    end

    // Drain and let any stray results show up
    wait_drained();
    repeat (64) @(posedge clk_i);
    $display("Sorted %0d runs from %0d items (%0d runs with dropped items), %0d results checked.",
             sb.runs_done, sb.items_in, sb.overflow_runs, sb.results_checked);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.failures);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/qsl_pkg.sv
rtl/qsl_ram.sv
rtl/quicksort_lomuto_engine.sv
tb/tb_quicksort_lomuto_engine.sv
